### hdl/elms_pkg.sv
package elms_pkg;

  // Fixed field widths
  localparam int MODE_W   = 2;
  localparam int VERTEX_W = 12;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 13;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_LABEL_WIDTH  = 32;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Transaction mode codes as seen on the input channel
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_EDGE,
    OP_READ,
    OP_NONE
  } op_t;

  // Classification produced by the front, consumed by the back
  typedef struct packed {
    op_t  op;
    logic edge_ok;   // source and target both below the vertex limit
    logic msg_ok;    // message address lies inside the store
    logic active;    // active flag carried by a load
    logic last;      // end-of-pass marker of an edge
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

### hdl/elms_in_if.sv
interface elms_in_if
  import elms_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [VERTEX_W-1:0]        vertex;
  logic signed [DATA_W-1:0]   label_in;
  logic signed [DATA_W-1:0]   message_in;
  logic                       active_in;
  logic [VERTEX_W-1:0]        edge_source;
  logic [VERTEX_W-1:0]        edge_target;
  logic                       last_edge;

  modport source (
    output valid, mode, vertex, label_in, message_in, active_in,
           edge_source, edge_target, last_edge,
    input  ready
  );

  modport sink (
    input  valid, mode, vertex, label_in, message_in, active_in,
           edge_source, edge_target, last_edge,
    output ready
  );
endinterface

### hdl/elms_out_if.sv
interface elms_out_if
  import elms_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     applied;
  logic signed [DATA_W-1:0] message_out;
  logic                     pass_done;

  modport source (
    output valid, applied, message_out, pass_done,
    input  ready
  );

  modport sink (
    input  valid, applied, message_out, pass_done,
    output ready
  );
endinterface

### hdl/elms_queue.sv
module elms_queue
  import elms_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hdl/elms_front.sv
module elms_front
  import elms_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int LABEL_WIDTH  = DEF_LABEL_WIDTH,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  elms_in_if.sink                 item,
  input  logic [COUNT_W-1:0]      vertex_count,
  input  logic                    q_full,
  output logic                    q_push,
  output cmd_ctrl_t               ctrl,
  output logic [AW-1:0]           src_addr,
  output logic [AW-1:0]           msg_addr,
  output logic signed [LABEL_WIDTH-1:0] label,
  output logic signed [LABEL_WIDTH-1:0] message
);

  localparam logic [31:0] CAP = 32'(MAX_VERTICES);

  logic vtx_cap;
  logic src_cap;
  logic dst_cap;
  logic src_cnt;
  logic dst_cnt;

  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full;

  // bounds: all below store capacity; edge endpoints also below the configured count
  assign vtx_cap = 32'(item.vertex) < CAP;
  assign src_cap = 32'(item.edge_source) < CAP;
  assign dst_cap = 32'(item.edge_target) < CAP;
  assign src_cnt = {1'b0, item.edge_source} < vertex_count;
  assign dst_cnt = {1'b0, item.edge_target} < vertex_count;

  always_comb begin
    ctrl         = '0;
    ctrl.active  = item.active_in;
    ctrl.last    = item.last_edge;
    ctrl.edge_ok = src_cap && src_cnt && dst_cap && dst_cnt;
    msg_addr     = AW'(item.vertex);
    case (item.mode)
      MODE_LOAD: begin
        ctrl.op     = OP_LOAD;
        ctrl.msg_ok = vtx_cap;
      end
      MODE_EDGE: begin
        ctrl.op     = OP_EDGE;
        ctrl.msg_ok = dst_cap;
        msg_addr    = AW'(item.edge_target);
      end
      MODE_READ: begin
        ctrl.op     = OP_READ;
        ctrl.msg_ok = vtx_cap;
      end
      default: begin
        ctrl.op     = OP_NONE;
        ctrl.msg_ok = 1'b0;
      end
    endcase
  end

  assign src_addr = AW'(item.edge_source);
  assign label    = LABEL_WIDTH'(item.label_in);
  assign message  = LABEL_WIDTH'(item.message_in);

endmodule

### hdl/elms_back.sv
module elms_back
  import elms_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int LABEL_WIDTH  = DEF_LABEL_WIDTH,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  cmd_ctrl_t                     q_ctrl,
  input  logic [AW-1:0]                 q_src,
  input  logic [AW-1:0]                 q_maddr,
  input  logic signed [LABEL_WIDTH-1:0] q_label,
  input  logic signed [LABEL_WIDTH-1:0] q_message,
  elms_out_if.source                    result
);

  localparam int LW = LABEL_WIDTH;

  // per-vertex stores
  logic signed [LW-1:0] label_mem  [MAX_VERTICES];
  logic                 active_mem [MAX_VERTICES];
  logic signed [LW-1:0] msg_mem    [MAX_VERTICES];

  // read stage
  logic                 s1_valid;
  cmd_ctrl_t            s1_ctrl;
  logic [AW-1:0]        s1_src;
  logic [AW-1:0]        s1_maddr;
  logic signed [LW-1:0] s1_label;
  logic signed [LW-1:0] s1_message;

  logic [AW-1:0]        raddr_src;
  logic [AW-1:0]        raddr_msg;
  logic signed [LW-1:0] rd_label;
  logic                 rd_active;
  logic signed [LW-1:0] rd_msg;

  // write-to-read forwarding
  logic                 byp_src_hit;
  logic signed [LW-1:0] byp_label;
  logic                 byp_active;
  logic                 byp_msg_hit;
  logic signed [LW-1:0] byp_msg;

  logic signed [LW-1:0] op_label;
  logic                 op_active;
  logic signed [LW-1:0] op_msg;

  logic                 exec;
  logic                 applied;
  logic signed [LW-1:0] new_msg;
  logic                 wr_load;
  logic                 wr_msg;
  logic signed [LW-1:0] wr_msg_data;

  logic                     out_valid;
  logic                     out_applied;
  logic signed [DATA_W-1:0] out_message;
  logic                     out_pass_done;
  logic                     applied_next;
  logic signed [DATA_W-1:0] message_next;
  logic                     pass_done_next;

  assign exec  = s1_valid && (!out_valid || result.ready);
  assign q_pop = !q_empty && (!s1_valid || exec);

  // stores are re-read every cycle at the held address so a waiting
  // command always sees the latest contents
  assign raddr_src = q_pop ? q_src   : s1_src;
  assign raddr_msg = q_pop ? q_maddr : s1_maddr;

  assign op_label  = byp_src_hit ? byp_label  : rd_label;
  assign op_active = byp_src_hit ? byp_active : rd_active;
  assign op_msg    = byp_msg_hit ? byp_msg    : rd_msg;

  assign applied = (s1_ctrl.op == OP_EDGE) && s1_ctrl.edge_ok && op_active;
  assign new_msg = (applied && (op_label < op_msg)) ? op_label : op_msg;

  assign wr_load     = exec && (s1_ctrl.op == OP_LOAD) && s1_ctrl.msg_ok;
  assign wr_msg      = wr_load || (exec && applied);
  assign wr_msg_data = (s1_ctrl.op == OP_LOAD) ? s1_message : new_msg;

  always_ff @(posedge clk) begin
    if (wr_load) begin
      label_mem[s1_maddr]  <= s1_label;
      active_mem[s1_maddr] <= s1_ctrl.active;
    end
    if (wr_msg) begin
      msg_mem[s1_maddr] <= wr_msg_data;
    end
    rd_label  <= label_mem[raddr_src];
    rd_active <= active_mem[raddr_src];
    rd_msg    <= msg_mem[raddr_msg];
  end

  always_ff @(posedge clk) begin
    byp_label  <= s1_label;
    byp_active <= s1_ctrl.active;
    byp_msg    <= wr_msg_data;
    if (rst) begin
      byp_src_hit <= 1'b0;
      byp_msg_hit <= 1'b0;
    end else begin
      byp_src_hit <= wr_load && (s1_maddr == raddr_src);
      byp_msg_hit <= wr_msg && (s1_maddr == raddr_msg);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctrl    <= q_ctrl;
      s1_src     <= q_src;
      s1_maddr   <= q_maddr;
      s1_label   <= q_label;
      s1_message <= q_message;
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (exec) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    applied_next   = 1'b0;
    message_next   = '0;
    pass_done_next = 1'b0;
    case (s1_ctrl.op)
      OP_LOAD: begin
        message_next = DATA_W'(s1_message);
      end
      OP_EDGE: begin
        applied_next   = applied;
        pass_done_next = s1_ctrl.last;
        if (s1_ctrl.msg_ok) begin
          message_next = DATA_W'(new_msg);
        end
      end
      OP_READ: begin
        if (s1_ctrl.msg_ok) begin
          message_next = DATA_W'(op_msg);
        end
      end
      default: begin
        message_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_applied   <= applied_next;
      out_message   <= message_next;
      out_pass_done <= pass_done_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.applied     = out_applied;
  assign result.message_out = out_message;
  assign result.pass_done   = out_pass_done;

endmodule

### hdl/edge_min_label_scatter.sv
// Scatter-min step of label-propagation connected components.
//
// Channels: "item" (sink) takes load, edge and read transactions; "result"
// (source) returns exactly one transaction per item, in order. Both use a
// valid/ready handshake. vertex_count is written through cfg_we/cfg_wdata
// and must only change while no item is in flight.
//
// Path: an item is written into the command queue, then the read stage, then
// the output register. Throughput: one transaction per cycle sustained while
// the result side is not stalled; the single read and write port of the
// message store sets it, with a forwarding path covering back-to-back edges
// that hit the same target.
//
// Reset (rst, synchronous) empties the command queue and pipeline and clears
// vertex_count. The vertex stores are not cleared: an entry reads garbage
// until a load writes it.
//
// Stall: when result is held off, the back end stops; the front keeps taking
// items until its QUEUE_DEPTH-entry command queue fills, then drops ready.
module edge_min_label_scatter
  import elms_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int LABEL_WIDTH  = DEF_LABEL_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  elms_in_if.sink            item,
  elms_out_if.source         result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int LW = LABEL_WIDTH;
  localparam int QW = CTRL_W + 2 * AW + 2 * LW;
  // items held at most: queue, read stage, output register
  localparam int FLIGHT_MAX = QUEUE_DEPTH + 2;
  localparam int FW = $clog2(FLIGHT_MAX + 1);

  logic [COUNT_W-1:0] vertex_count;

  // front -> queue
  logic                 q_push;
  logic                 q_full;
  cmd_ctrl_t            f_ctrl;
  logic [AW-1:0]        f_src;
  logic [AW-1:0]        f_maddr;
  logic signed [LW-1:0] f_label;
  logic signed [LW-1:0] f_message;

  // queue -> back
  logic                 q_pop;
  logic                 q_empty;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  cmd_ctrl_t            q_ctrl;
  logic [AW-1:0]        q_src;
  logic [AW-1:0]        q_maddr;
  logic signed [LW-1:0] q_label;
  logic signed [LW-1:0] q_message;

  // transactions accepted but not yet delivered
  logic [FW-1:0] flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // Front: bounds checks and decode, no store access
  elms_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_WIDTH  (LABEL_WIDTH)
  ) u_front (
    .item         (item),
    .vertex_count (vertex_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .ctrl         (f_ctrl),
    .src_addr     (f_src),
    .msg_addr     (f_maddr),
    .label        (f_label),
    .message      (f_message)
  );

  assign q_wdata = {f_ctrl, f_src, f_maddr, f_label, f_message};
  assign {q_ctrl, q_src, q_maddr, q_label, q_message} = q_rdata;

  elms_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: store reads, min update with forwarding, result register
  elms_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_WIDTH  (LABEL_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctrl    (q_ctrl),
    .q_src     (q_src),
    .q_maddr   (q_maddr),
    .q_label   (q_label),
    .q_message (q_message),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else if ((item.valid && item.ready) && !(result.valid && result.ready)) begin
      flight <= flight + FW'(1);
    end else if (!(item.valid && item.ready) && (result.valid && result.ready)) begin
      flight <= flight - FW'(1);
    end
  end

  // never more transactions in flight than the storage can hold
  a_flight_bound: assert property (@(posedge clk) disable iff (rst)
    flight <= FW'(FLIGHT_MAX))
    else $error("in-flight transaction count exceeds storage");

  // a result only appears for an accepted item
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> flight != '0)
    else $error("result without an accepted item");

  // with no valid vertices no edge may be applied
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && (vertex_count == '0) |-> !result.applied)
    else $error("edge applied with zero vertex count");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
